// File: rtl/ptb_pkg.sv
// Shared types, codes and sizes for the periodic timer bank.
package ptb_pkg;

	// Bank size and derived widths
	localparam int NUM_TIMERS = 16;
	localparam int IDX_W      = $clog2(NUM_TIMERS);
	localparam int CNT_W      = $clog2(NUM_TIMERS + 1);

	// Operation codes
	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_ADD    = 3'd1;
	localparam logic [2:0] OP_REMOVE = 3'd2;
	localparam logic [2:0] OP_REACT  = 3'd3;
	localparam logic [2:0] OP_PERIOD = 3'd4;
	localparam logic [2:0] OP_TEST   = 3'd5;

	// Result kinds
	localparam logic [2:0] KIND_FIRE       = 3'd0;
	localparam logic [2:0] KIND_TICK_DONE  = 3'd1;
	localparam logic [2:0] KIND_ADD_ACK    = 3'd2;
	localparam logic [2:0] KIND_REMOVE_ACK = 3'd3;
	localparam logic [2:0] KIND_REACT_ACK  = 3'd4;
	localparam logic [2:0] KIND_PERIOD_ACK = 3'd5;
	localparam logic [2:0] KIND_TEST_ACK   = 3'd6;

	// One operation request
	typedef struct packed {
		logic [2:0]  opcode;
		logic [3:0]  slot;
		logic [31:0] period_len;
		logic [31:0] delay_len;
		logic [7:0]  new_reason;
		logic        has_action;
		logic        has_exit;
	} request_t;

	// One result
	typedef struct packed {
		logic [2:0] kind;
		logic [3:0] result_slot;
		logic [7:0] fire_reason;
		logic       ok;
		logic [4:0] fired_count;
		logic       exit_notice;
		logic       last;
	} result_t;

	// Controller to datapath commands
	typedef struct packed {
		logic             load;
		logic             scan_rd;
		logic [IDX_W-1:0] scan_addr;
		logic             exec;
		logic             tick_done;
	} dp_cmd_t;

	// Datapath to controller status: decode of the offered opcode
	typedef struct packed {
		logic is_tick;
		logic is_defined;
	} dp_status_t;

endpackage

// File: rtl/ptb_ctrl.sv
// Sequencer for the timer bank: accepts operations and steps the slot scan.
module ptb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ptb_pkg::dp_status_t status,
	output ptb_pkg::dp_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_FLUSH = 3'd2;
	localparam logic [2:0] ST_TDONE = 3'd3;
	localparam logic [2:0] ST_READ  = 3'd4;
	localparam logic [2:0] ST_EXEC  = 3'd5;

	logic [2:0]                state_q, state_d;
	logic [ptb_pkg::IDX_W-1:0] cnt_q, cnt_d;
	logic                      accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		cmd           = '0;
		cmd.scan_addr = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					if (status.is_tick)
						state_d = ST_SCAN;
					else if (status.is_defined)
						state_d = ST_READ;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (cnt_q == ptb_pkg::IDX_W'(ptb_pkg::NUM_TIMERS - 1))
					state_d = ST_FLUSH;
				else
					cnt_d = cnt_q + 1'b1;
			end
			ST_FLUSH: state_d = ST_TDONE;
			ST_TDONE: begin
				cmd.tick_done = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_READ:  state_d = ST_EXEC;
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// File: rtl/ptb_datapath.sv
// Timer slot storage, time count, expiry compare and result register.
module ptb_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  ptb_pkg::request_t   request,
	input  logic                cfg_valid,
	input  logic [7:0]          cfg_data,
	input  ptb_pkg::dp_cmd_t    cmd,
	output ptb_pkg::dp_status_t status,
	output ptb_pkg::result_t    result,
	output logic                strobe
);

	localparam int N  = ptb_pkg::NUM_TIMERS;
	localparam int IW = ptb_pkg::IDX_W;

	// Slot memories
	logic [63:0] expiry_mem [N];
	logic [31:0] period_mem [N];
	logic [7:0]  reason_mem [N];
	logic        action_mem [N];
	logic        exit_mem   [N];

	logic [7:0]                default_reason_q;
	logic [63:0]               now_q;
	logic [N-1:0]              active_q;
	ptb_pkg::request_t         req_q;
	logic [ptb_pkg::CNT_W-1:0] fire_cnt_q;

	// Read stage
	logic [63:0]   rd_exp_s1;
	logic [31:0]   rd_per_s1;
	logic [7:0]    rd_rsn_s1;
	logic          rd_act_s1;
	logic          rd_exit_s1;
	logic [IW-1:0] rd_idx_s1;
	logic          scan_s1;

	ptb_pkg::result_t result_q;
	logic             strobe_q;

	logic [IW-1:0] slot_idx, rd_addr, free_idx, wr_idx;
	logic          slot_ok, free_found, due;
	logic [63:0]   diff, fire_exp, delay_exp;
	logic          we_exp, we_per, we_rsn, we_flags;
	logic [63:0]   wd_exp;
	logic [7:0]    wd_rsn;
	logic          set_active, clr_active;
	ptb_pkg::result_t res_d;
	logic             res_we;

	assign status.is_tick    = (request.opcode == ptb_pkg::OP_TICK);
	assign status.is_defined = (request.opcode == ptb_pkg::OP_TICK)
		|| (request.opcode == ptb_pkg::OP_ADD) || (request.opcode == ptb_pkg::OP_REMOVE)
		|| (request.opcode == ptb_pkg::OP_REACT) || (request.opcode == ptb_pkg::OP_PERIOD)
		|| (request.opcode == ptb_pkg::OP_TEST);

	assign slot_idx = IW'(req_q.slot);
	assign slot_ok  = (32'(req_q.slot) < 32'(N)) && active_q[slot_idx];
	assign rd_addr  = cmd.scan_rd ? cmd.scan_addr : slot_idx;

	// Expiry compare: due when expiry minus now is negative
	assign diff      = rd_exp_s1 - now_q;
	assign due       = scan_s1 && active_q[rd_idx_s1] && rd_act_s1 && diff[63];
	assign fire_exp  = now_q + 64'(rd_per_s1);
	assign delay_exp = now_q + 64'(req_q.delay_len);

	// Lowest free slot
	always_comb begin
		free_idx   = '0;
		free_found = 1'b0;
		for (int i = N - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_idx   = IW'(i);
				free_found = 1'b1;
			end
		end
	end

	// Write control and result build
	always_comb begin
		we_exp     = 1'b0;
		we_per     = 1'b0;
		we_rsn     = 1'b0;
		we_flags   = 1'b0;
		wr_idx     = slot_idx;
		wd_exp     = delay_exp;
		wd_rsn     = default_reason_q;
		set_active = 1'b0;
		clr_active = 1'b0;
		res_d      = '0;
		res_we     = 1'b0;
		if (due) begin
			we_exp            = 1'b1;
			we_rsn            = 1'b1;
			wr_idx            = rd_idx_s1;
			wd_exp            = fire_exp;
			res_we            = 1'b1;
			res_d.kind        = ptb_pkg::KIND_FIRE;
			res_d.result_slot = 4'(rd_idx_s1);
			res_d.fire_reason = rd_rsn_s1;
			res_d.ok          = 1'b1;
		end else if (cmd.tick_done) begin
			res_we            = 1'b1;
			res_d.kind        = ptb_pkg::KIND_TICK_DONE;
			res_d.ok          = 1'b1;
			res_d.fired_count = 5'(fire_cnt_q);
			res_d.last        = 1'b1;
		end else if (cmd.exec) begin
			res_we            = 1'b1;
			res_d.last        = 1'b1;
			res_d.result_slot = req_q.slot;
			case (req_q.opcode)
				ptb_pkg::OP_ADD: begin
					res_d.kind        = ptb_pkg::KIND_ADD_ACK;
					res_d.ok          = free_found;
					res_d.result_slot = free_found ? 4'(free_idx) : 4'd0;
					wr_idx            = free_idx;
					we_exp            = free_found;
					we_per            = free_found;
					we_rsn            = free_found;
					we_flags          = free_found;
					set_active        = free_found;
				end
				ptb_pkg::OP_REMOVE: begin
					res_d.kind        = ptb_pkg::KIND_REMOVE_ACK;
					res_d.ok          = slot_ok;
					res_d.exit_notice = slot_ok && rd_exit_s1;
					clr_active        = slot_ok;
				end
				ptb_pkg::OP_REACT: begin
					res_d.kind = ptb_pkg::KIND_REACT_ACK;
					res_d.ok   = slot_ok;
					we_exp     = slot_ok;
					we_rsn     = slot_ok;
					wd_rsn     = req_q.new_reason;
				end
				ptb_pkg::OP_PERIOD: begin
					res_d.kind = ptb_pkg::KIND_PERIOD_ACK;
					res_d.ok   = slot_ok && (req_q.period_len != 32'd0);
					we_per     = res_d.ok;
				end
				ptb_pkg::OP_TEST: begin
					res_d.kind = ptb_pkg::KIND_TEST_ACK;
					res_d.ok   = slot_ok;
				end
				default: res_we = 1'b0;
			endcase
		end
	end

	// Memory writes and registered reads
	always_ff @(posedge clk) begin
		if (we_exp)
			expiry_mem[wr_idx] <= wd_exp;
		if (we_per)
			period_mem[wr_idx] <= req_q.period_len;
		if (we_rsn)
			reason_mem[wr_idx] <= wd_rsn;
		if (we_flags) begin
			action_mem[wr_idx] <= req_q.has_action;
			exit_mem[wr_idx]   <= req_q.has_exit;
		end
		rd_exp_s1  <= expiry_mem[rd_addr];
		rd_per_s1  <= period_mem[rd_addr];
		rd_rsn_s1  <= reason_mem[rd_addr];
		rd_act_s1  <= action_mem[rd_addr];
		rd_exit_s1 <= exit_mem[rd_addr];
		rd_idx_s1  <= rd_addr;
	end

	// Latched request and fire count
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q      <= request;
			fire_cnt_q <= '0;
		end else if (due) begin
			fire_cnt_q <= fire_cnt_q + 1'b1;
		end
		if (res_we)
			result_q <= res_d;
	end

	// Control state: time, active bits, default reason, strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_reason_q <= '0;
			now_q            <= '0;
			active_q         <= '0;
			scan_s1          <= 1'b0;
			strobe_q         <= 1'b0;
		end else begin
			if (cfg_valid)
				default_reason_q <= cfg_data;
			if (cmd.load && status.is_tick)
				now_q <= now_q + 64'd1;
			if (set_active)
				active_q[wr_idx] <= 1'b1;
			if (clr_active)
				active_q[slot_idx] <= 1'b0;
			scan_s1  <= cmd.scan_rd;
			strobe_q <= res_we;
		end
	end

	assign result = result_q;
	assign strobe = strobe_q;

endmodule

// File: rtl/periodic_timer_bank_unit.sv
// Top level of the periodic timer bank: sequencer plus slot datapath.
//
// Channel   Direction  Signals                     Transfer
// request   in         start, busy, request        start high while busy low
// result    out        strobe, result              strobe high, one cycle each
// config    in         cfg_valid, cfg_ready, data  cfg_valid and cfg_ready high
//
// A tick scans every slot: one slot is read from the slot memory per cycle, and the
// compare and write-back act on the registered read in the cycle after it.
// Other operations read the slot, then update and acknowledge; undefined codes give no result.
// Results are registered and appear in the cycle after they are decided; the receiver cannot stall them.
// Reset clears time, active bits, default reason and the strobe; no clearing pass.
module periodic_timer_bank_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ptb_pkg::request_t request,
	output logic              strobe,
	output ptb_pkg::result_t  result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        cfg_data
);

	ptb_pkg::dp_cmd_t    cmd;
	ptb_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	ptb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	ptb_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.result    (result),
		.strobe    (strobe)
	);

endmodule

// File: sim/periodic_timer_bank_checker.sv
// Checker for the periodic timer bank: shadow model, expected result queue and compare.
module periodic_timer_bank_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  ptb_pkg::request_t request,
	input  logic              strobe,
	input  ptb_pkg::result_t  result,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [7:0]        cfg_data,
	output int                mismatches,
	output int                outstanding
);

	// Shadow copy of the bank
	logic [7:0]  shadow_default;
	logic [63:0] shadow_now;
	logic        shadow_active [ptb_pkg::NUM_TIMERS];
	logic [63:0] shadow_expiry [ptb_pkg::NUM_TIMERS];
	logic [31:0] shadow_period [ptb_pkg::NUM_TIMERS];
	logic [7:0]  shadow_reason [ptb_pkg::NUM_TIMERS];
	logic        shadow_action [ptb_pkg::NUM_TIMERS];
	logic        shadow_exit   [ptb_pkg::NUM_TIMERS];

	ptb_pkg::result_t awaited_results [$];

	function automatic ptb_pkg::result_t make_result(logic [2:0] kind, logic [3:0] slot,
			logic [7:0] reason, logic ok, logic [4:0] count, logic exitn, logic last);
		ptb_pkg::result_t r;
		r.kind        = kind;
		r.result_slot = slot;
		r.fire_reason = reason;
		r.ok          = ok;
		r.fired_count = count;
		r.exit_notice = exitn;
		r.last        = last;
		return r;
	endfunction

	function automatic string fmt_result(ptb_pkg::result_t r);
		return $sformatf("kind=%0d slot=%0d reason=0x%02h ok=%0b count=%0d exit=%0b last=%0b",
			r.kind, r.result_slot, r.fire_reason, r.ok, r.fired_count, r.exit_notice, r.last);
	endfunction

	// Apply one accepted operation to the shadow bank and queue what it should produce
	task automatic predict_operation(input ptb_pkg::request_t rq);
		int         fired;
		int         free_slot;
		logic       hit;
		logic [63:0] gap;
		fired     = 0;
		free_slot = -1;
		hit       = shadow_active[rq.slot];
		case (rq.opcode)
			ptb_pkg::OP_TICK: begin
				shadow_now = shadow_now + 64'd1;
				for (int i = 0; i < ptb_pkg::NUM_TIMERS; i++) begin
					if (!shadow_active[i] || !shadow_action[i])
						continue;
					// due when expiry minus now is negative modulo 2^64
					gap = shadow_expiry[i] - shadow_now;
					if (!gap[63])
						continue;
					awaited_results.push_back(make_result(ptb_pkg::KIND_FIRE, 4'(i),
						shadow_reason[i], 1'b1, 5'd0, 1'b0, 1'b0));
					fired++;
					shadow_reason[i] = shadow_default;
					shadow_expiry[i] = shadow_now + {32'd0, shadow_period[i]};
				end
				awaited_results.push_back(make_result(ptb_pkg::KIND_TICK_DONE, 4'd0, 8'd0,
					1'b1, 5'(fired), 1'b0, 1'b1));
			end
			ptb_pkg::OP_ADD: begin
				for (int i = ptb_pkg::NUM_TIMERS - 1; i >= 0; i--)
					if (!shadow_active[i])
						free_slot = i;
				if (free_slot < 0) begin
					awaited_results.push_back(make_result(ptb_pkg::KIND_ADD_ACK, 4'd0, 8'd0,
						1'b0, 5'd0, 1'b0, 1'b1));
				end else begin
					shadow_active[free_slot] = 1'b1;
					shadow_expiry[free_slot] = shadow_now + {32'd0, rq.delay_len};
					shadow_period[free_slot] = rq.period_len;
					shadow_reason[free_slot] = shadow_default;
					shadow_action[free_slot] = rq.has_action;
					shadow_exit[free_slot]   = rq.has_exit;
					awaited_results.push_back(make_result(ptb_pkg::KIND_ADD_ACK,
						4'(free_slot), 8'd0, 1'b1, 5'd0, 1'b0, 1'b1));
				end
			end
			ptb_pkg::OP_REMOVE: begin
				awaited_results.push_back(make_result(ptb_pkg::KIND_REMOVE_ACK, rq.slot, 8'd0,
					hit, 5'd0, hit & shadow_exit[rq.slot], 1'b1));
				if (hit)
					shadow_active[rq.slot] = 1'b0;
			end
			ptb_pkg::OP_REACT: begin
				if (hit) begin
					shadow_reason[rq.slot] = rq.new_reason;
					shadow_expiry[rq.slot] = shadow_now + {32'd0, rq.delay_len};
				end
				awaited_results.push_back(make_result(ptb_pkg::KIND_REACT_ACK, rq.slot, 8'd0,
					hit, 5'd0, 1'b0, 1'b1));
			end
			ptb_pkg::OP_PERIOD: begin
				// a zero period is refused
				if (rq.period_len == 32'd0)
					hit = 1'b0;
				if (hit)
					shadow_period[rq.slot] = rq.period_len;
				awaited_results.push_back(make_result(ptb_pkg::KIND_PERIOD_ACK, rq.slot, 8'd0,
					hit, 5'd0, 1'b0, 1'b1));
			end
			ptb_pkg::OP_TEST: begin
				awaited_results.push_back(make_result(ptb_pkg::KIND_TEST_ACK, rq.slot, 8'd0,
					hit, 5'd0, 1'b0, 1'b1));
			end
			default: begin
				// undefined codes give nothing
			end
		endcase
	endtask

	// Sample all channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		ptb_pkg::result_t want;
		if (!arst_n) begin
			shadow_default = 8'd0;
			shadow_now     = 64'd0;
			for (int i = 0; i < ptb_pkg::NUM_TIMERS; i++) begin
				shadow_active[i] = 1'b0;
				shadow_expiry[i] = 64'd0;
				shadow_period[i] = 32'd0;
				shadow_reason[i] = 8'd0;
				shadow_action[i] = 1'b0;
				shadow_exit[i]   = 1'b0;
			end
			awaited_results.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			// compare a result transfer with the oldest expectation
			if (strobe === 1'b1) begin
				if (awaited_results.size() == 0) begin
					$display("%0t unexpected result: expected none, actual %s",
						$time, fmt_result(result));
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					if (result.kind !== want.kind || result.result_slot !== want.result_slot ||
							result.fire_reason !== want.fire_reason ||
							result.ok !== want.ok || result.fired_count !== want.fired_count ||
							result.exit_notice !== want.exit_notice ||
							result.last !== want.last) begin
						$display("%0t result mismatch: expected %s, actual %s",
							$time, fmt_result(want), fmt_result(result));
						mismatches++;
					end
				end
			end
			// register write transfer
			if (cfg_valid && cfg_ready)
				shadow_default = cfg_data;
			// request transfer
			if (start && !busy)
				predict_operation(request);
			outstanding = awaited_results.size();
		end
	end

endmodule

// File: sim/periodic_timer_bank_unit_test.sv
// Testbench top for the periodic timer bank: clock, reset, stimulus and verdict.
module periodic_timer_bank_unit_test;

	localparam logic [2:0] OP_UNDEF_LO = 3'd6;
	localparam logic [2:0] OP_UNDEF_HI = 3'd7;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 30;
	localparam int PHASE_ITEMS   = 80;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	ptb_pkg::request_t request;
	logic              strobe;
	ptb_pkg::result_t  result;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [7:0]        cfg_data;
	int                mismatches;
	int                outstanding;
	int                cycle_count;

	periodic_timer_bank_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.strobe    (strobe),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	periodic_timer_bank_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.request     (request),
		.strobe      (strobe),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// 20-unit clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic ptb_pkg::request_t mk_req(logic [2:0] op, logic [3:0] slot,
			logic [31:0] period, logic [31:0] delay, logic [7:0] reason, logic act, logic ex);
		ptb_pkg::request_t rq;
		rq.opcode     = op;
		rq.slot       = slot;
		rq.period_len = period;
		rq.delay_len  = delay;
		rq.new_reason = reason;
		rq.has_action = act;
		rq.has_exit   = ex;
		return rq;
	endfunction

	// Mostly short times so that timers fire, now and then a full-width value
	function automatic logic [31:0] draw_time(int short_max);
		if ($urandom_range(0, 7) == 0)
			return $urandom;
		return 32'($urandom_range(0, short_max));
	endfunction

	function automatic ptb_pkg::request_t draw_request(int add_pct, int rem_pct);
		int         pick;
		logic [2:0] op;
		pick = $urandom_range(0, 99);
		if (pick < add_pct)
			op = ptb_pkg::OP_ADD;
		else if (pick < add_pct + rem_pct)
			op = ptb_pkg::OP_REMOVE;
		else if (pick < add_pct + rem_pct + 8)
			op = ptb_pkg::OP_REACT;
		else if (pick < add_pct + rem_pct + 14)
			op = ptb_pkg::OP_PERIOD;
		else if (pick < add_pct + rem_pct + 19)
			op = ptb_pkg::OP_TEST;
		else if (pick < add_pct + rem_pct + 22)
			op = $urandom_range(0, 1) ? OP_UNDEF_HI : OP_UNDEF_LO;
		else
			op = ptb_pkg::OP_TICK;
		return mk_req(op, 4'($urandom_range(0, 15)), draw_time(4), draw_time(6),
			8'($urandom_range(0, 255)), $urandom_range(0, 4) != 0, 1'($urandom_range(0, 1)));
	endfunction

	// Offer one request, hold it until the transfer, then idle for a random gap unless gaps are off
	task automatic send_request(input ptb_pkg::request_t rq, input bit no_gaps);
		int gap;
		start   <= 1'b1;
		request <= rq;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Stop sending and wait until every expected result has arrived, then let it settle
	task automatic drain_results();
		start <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_default_reason(input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stimulus
	initial begin
		int add_pct [5];
		int rem_pct [5];
		logic [7:0] phase_reason [5];
		int sent;
		bit burst;
		ptb_pkg::request_t rq;

		add_pct = '{45, 20, 10, 30, 25};
		rem_pct = '{5, 15, 25, 10, 12};
		phase_reason = '{8'hFF, 8'h00, 8'($urandom_range(0, 255)), 8'h80,
			8'($urandom_range(0, 255))};

		arst_n    = 1'b0;
		start     = 1'b0;
		request   = '0;
		cfg_valid = 1'b0;
		cfg_data  = 8'd0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_default_reason(8'h3C);

		// Directed: inactive slots, field extremes, firing, refusals, undefined codes
		send_request(mk_req(ptb_pkg::OP_TEST, 4'd0, 32'd0, 32'd0, 8'd0, 1'b0, 1'b0), 1'b0);
		send_request(mk_req(ptb_pkg::OP_REMOVE, 4'd15, 32'd0, 32'd0, 8'd0, 1'b0, 1'b0),
			1'b0);
		send_request(mk_req(ptb_pkg::OP_REACT, 4'd3, 32'd0, 32'd1, 8'h11, 1'b0, 1'b0), 1'b0);
		send_request(mk_req(ptb_pkg::OP_PERIOD, 4'd2, 32'd5, 32'd0, 8'd0, 1'b0, 1'b0), 1'b0);
		send_request(mk_req(ptb_pkg::OP_ADD, 4'd0, 32'd0, 32'd0, 8'd0, 1'b1, 1'b1), 1'b0);
		send_request(mk_req(ptb_pkg::OP_ADD, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1,
			1'b0), 1'b0);
		send_request(mk_req(ptb_pkg::OP_ADD, 4'd0, 32'd2, 32'd0, 8'd0, 1'b0, 1'b1), 1'b0);
		send_request(mk_req(ptb_pkg::OP_ADD, 4'd0, 32'd1, 32'd1, 8'd0, 1'b1, 1'b0), 1'b0);
		send_request(mk_req(ptb_pkg::OP_TICK, 4'd0, 32'd0, 32'd0, 8'd0, 1'b0, 1'b0), 1'b0);
		send_request(mk_req(ptb_pkg::OP_TICK, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
			1'b1, 1'b1), 1'b0);
		send_request(mk_req(ptb_pkg::OP_TEST, 4'd0, 32'd0, 32'd0, 8'd0, 1'b0, 1'b0), 1'b0);
		send_request(mk_req(ptb_pkg::OP_TEST, 4'd9, 32'd0, 32'd0, 8'd0, 1'b0, 1'b0), 1'b0);
		send_request(mk_req(ptb_pkg::OP_PERIOD, 4'd0, 32'd0, 32'd0, 8'd0, 1'b0, 1'b0), 1'b0);
		send_request(mk_req(ptb_pkg::OP_PERIOD, 4'd0, 32'd3, 32'd0, 8'd0, 1'b0, 1'b0), 1'b0);
		send_request(mk_req(ptb_pkg::OP_REACT, 4'd1, 32'd0, 32'd0, 8'hFF, 1'b0, 1'b0), 1'b0);
		send_request(mk_req(ptb_pkg::OP_TICK, 4'd0, 32'd0, 32'd0, 8'd0, 1'b0, 1'b0), 1'b0);
		send_request(mk_req(OP_UNDEF_LO, 4'd0, 32'd0, 32'd0, 8'd0, 1'b0, 1'b0), 1'b0);
		send_request(mk_req(OP_UNDEF_HI, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1,
			1'b1), 1'b0);
		send_request(mk_req(ptb_pkg::OP_REMOVE, 4'd0, 32'd0, 32'd0, 8'd0, 1'b0, 1'b0), 1'b0);
		send_request(mk_req(ptb_pkg::OP_REMOVE, 4'd0, 32'd0, 32'd0, 8'd0, 1'b0, 1'b0), 1'b0);
		send_request(mk_req(ptb_pkg::OP_REMOVE, 4'd1, 32'd0, 32'd0, 8'd0, 1'b0, 1'b0), 1'b0);
		send_request(mk_req(ptb_pkg::OP_TICK, 4'd0, 32'd0, 32'd0, 8'd0, 1'b0, 1'b0), 1'b0);
		send_request(mk_req(ptb_pkg::OP_ADD, 4'd7, 32'd1, 32'd0, 8'h5A, 1'b1, 1'b1), 1'b0);
		send_request(mk_req(ptb_pkg::OP_TEST, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
			1'b1, 1'b1), 1'b0);
		drain_results();

		// Random phases, each under its own default reason and operation mix
		for (int p = 0; p < 5; p++) begin
			write_default_reason(phase_reason[p]);
			sent  = 0;
			burst = 1'b0;
			while (sent < PHASE_ITEMS) begin
				if (sent % 20 == 0)
					burst = ($urandom_range(0, 2) == 0);
				rq = draw_request(add_pct[p], rem_pct[p]);
				send_request(rq, burst);
				if (rq.opcode != OP_UNDEF_LO && rq.opcode != OP_UNDEF_HI)
					sent++;
			end
			drain_results();
		end

		if (mismatches == 0 && outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: sim.f
rtl/ptb_pkg.sv
rtl/ptb_ctrl.sv
rtl/ptb_datapath.sv
rtl/periodic_timer_bank_unit.sv
sim/periodic_timer_bank_checker.sv
sim/periodic_timer_bank_unit_test.sv
